// ===== hdl/pwst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_pkg
// Shared codes, reset values and controller/datapath interface types for the
// pulse-width serial transceiver.
// ----------------------------------------------------------------------------
package pwst_pkg;

   // request selector carried on req_tuser
   localparam logic [1:0] ACTION_TICK  = 2'd0;
   localparam logic [1:0] ACTION_PULSE = 2'd1;
   localparam logic [1:0] ACTION_SEND  = 2'd2;

   // result kind carried on rsp_tuser
   localparam logic KIND_SYMBOL = 1'b0;
   localparam logic KIND_FRAME  = 1'b1;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_LIMIT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_LIMIT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW       = 3'd6;

   // field widths
   localparam int WIDTH_W = 24;
   localparam int TIME_W  = 16;
   localparam int WORD_W  = 32;

   // reset values
   localparam logic [WIDTH_W-1:0] SHORT_LIMIT_RST   = 24'd50000;
   localparam logic [WIDTH_W-1:0] LONG_LIMIT_RST    = 24'd200000;
   localparam logic [TIME_W-1:0]  TIMEOUT_LIMIT_RST = 16'd2000;
   localparam logic [TIME_W-1:0]  ZERO_HIGH_RST     = 16'd100;
   localparam logic [TIME_W-1:0]  ZERO_LOW_RST      = 16'd875;
   localparam logic [TIME_W-1:0]  ONE_HIGH_RST      = 16'd650;
   localparam logic [TIME_W-1:0]  ONE_LOW_RST       = 16'd325;

   localparam logic [TIME_W-1:0]  IDLE_MAX = 16'hFFFF;

   typedef struct packed {
      logic tick_en;
      logic pulse_en;
      logic send_en;
      logic skip_en;
      logic emit_en;
   } cmd_type;

   typedef struct packed {
      logic timeout_hit;
      logic tx_empty;
      logic tx_msb;
      logic tx_final;
   } status_type;

endpackage

// ===== hdl/pwst_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_dp
// Datapath: settings, receive shift register, idle counter, transmit shift
// register with bit count, and the result register.
// ----------------------------------------------------------------------------
module pwst_dp #(
   parameter int FRAME_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pwst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwst_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic [pwst_pkg::WIDTH_W-1:0]     pulse_width,
   input  logic [pwst_pkg::WORD_W-1:0]      frame_to_send,
   input  pwst_pkg::cmd_type                cmd,
   output pwst_pkg::status_type             status,
   output logic                             kind,
   output logic                             bit_value,
   output logic [pwst_pkg::TIME_W-1:0]      high_time,
   output logic [pwst_pkg::TIME_W-1:0]      low_time,
   output logic                             last,
   output logic [pwst_pkg::WORD_W-1:0]      received_frame
);
   import pwst_pkg::*;

   localparam int SEND_BITS = (FRAME_BITS < WORD_W) ? FRAME_BITS : WORD_W;
   localparam int WIDE_W    = (FRAME_BITS > WORD_W) ? FRAME_BITS : WORD_W;
   localparam int CNT_W     = $clog2(SEND_BITS + 1);

   logic [WIDTH_W-1:0]    short_limit_ff, long_limit_ff;
   logic [TIME_W-1:0]     timeout_limit_ff;
   logic [TIME_W-1:0]     zero_high_ff, zero_low_ff, one_high_ff, one_low_ff;

   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic                  started_ff, started_in;
   logic [TIME_W-1:0]     idle_ff, idle_in;
   logic [SEND_BITS-1:0]  tx_ff, tx_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  kind_ff, kind_in;
   logic                  bit_ff, bit_in;
   logic [TIME_W-1:0]     high_ff, high_in;
   logic [TIME_W-1:0]     low_ff, low_in;
   logic                  last_ff, last_in;
   logic [WORD_W-1:0]     frame_ff, frame_in;

   logic [TIME_W-1:0]     idle_inc;
   logic [WIDE_W-1:0]     rx_ext;
   logic                  width_zero, width_one;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff   <= SHORT_LIMIT_RST;
         long_limit_ff    <= LONG_LIMIT_RST;
         timeout_limit_ff <= TIMEOUT_LIMIT_RST;
         zero_high_ff     <= ZERO_HIGH_RST;
         zero_low_ff      <= ZERO_LOW_RST;
         one_high_ff      <= ONE_HIGH_RST;
         one_low_ff       <= ONE_LOW_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHORT_LIMIT:   short_limit_ff   <= csr_data;
            CSR_LONG_LIMIT:    long_limit_ff    <= csr_data;
            CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_data[TIME_W-1:0];
            CSR_ZERO_HIGH:     zero_high_ff     <= csr_data[TIME_W-1:0];
            CSR_ZERO_LOW:      zero_low_ff      <= csr_data[TIME_W-1:0];
            CSR_ONE_HIGH:      one_high_ff      <= csr_data[TIME_W-1:0];
            CSR_ONE_LOW:       one_low_ff       <= csr_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      idle_inc   = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
      rx_ext     = WIDE_W'(shift_ff);
      width_zero = pulse_width < short_limit_ff;
      width_one  = (pulse_width > short_limit_ff) && (pulse_width < long_limit_ff);

      status.timeout_hit = started_ff && (idle_inc > timeout_limit_ff);
      status.tx_empty    = (tx_ff == '0);
      status.tx_msb      = tx_ff[SEND_BITS-1];
      status.tx_final    = (count_ff == CNT_W'(1));

      shift_in   = shift_ff;
      started_in = started_ff;
      idle_in    = idle_ff;
      tx_in      = tx_ff;
      count_in   = count_ff;
      kind_in    = kind_ff;
      bit_in     = bit_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      last_in    = last_ff;
      frame_in   = frame_ff;

      if (cmd.tick_en) begin
         idle_in = idle_inc;
         if (status.timeout_hit) begin
            shift_in   = '0;
            started_in = 1'b0;
            kind_in    = KIND_FRAME;
            bit_in     = 1'b0;
            high_in    = '0;
            low_in     = '0;
            last_in    = 1'b0;
            frame_in   = rx_ext[WORD_W-1:0];
         end
      end

      if (cmd.pulse_en) begin
         started_in = 1'b1;
         idle_in    = '0;
         if (width_zero)
            shift_in = {shift_ff[FRAME_BITS-2:0], 1'b0};
         else if (width_one)
            shift_in = {shift_ff[FRAME_BITS-2:0], 1'b1};
      end

      if (cmd.send_en) begin
         started_in = 1'b0;
         idle_in    = '0;
         tx_in      = SEND_BITS'(frame_to_send);
         count_in   = CNT_W'(SEND_BITS);
      end

      // leading zeros drop out one per cycle
      if (cmd.skip_en) begin
         tx_in    = tx_ff << 1;
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.emit_en) begin
         kind_in  = KIND_SYMBOL;
         bit_in   = status.tx_msb;
         high_in  = status.tx_msb ? one_high_ff : zero_high_ff;
         low_in   = status.tx_msb ? one_low_ff : zero_low_ff;
         last_in  = status.tx_final;
         frame_in = '0;
         tx_in    = tx_ff << 1;
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff   <= '0;
         started_ff <= 1'b0;
         idle_ff    <= '0;
      end else begin
         shift_ff   <= shift_in;
         started_ff <= started_in;
         idle_ff    <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff    <= tx_in;
      count_ff <= count_in;
      kind_ff  <= kind_in;
      bit_ff   <= bit_in;
      high_ff  <= high_in;
      low_ff   <= low_in;
      last_ff  <= last_in;
      frame_ff <= frame_in;
   end

   assign kind           = kind_ff;
   assign bit_value      = bit_ff;
   assign high_time      = high_ff;
   assign low_time       = low_ff;
   assign last           = last_ff;
   assign received_frame = frame_ff;

   // a symbol is only ever taken from a non-empty count
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en |-> (count_ff != '0))
      else $error("emit with zero bit count");

endmodule

// ===== hdl/pwst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwst_ctrl
// Controller: request decode, send sequencing and result-valid tracking.
// ----------------------------------------------------------------------------
module pwst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           action,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pwst_pkg::status_type status,
   output pwst_pkg::cmd_type    cmd
);
   import pwst_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SKIP = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;
   logic       req_fire;

   assign out_free = !valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff && !rsp_tready;
      req_tready = 1'b0;
      cmd        = '0;

      case (state_ff)
         S_IDLE: begin
            req_tready = out_free;
            if (req_fire) begin
               case (action)
                  ACTION_TICK: begin
                     cmd.tick_en = 1'b1;
                     if (status.timeout_hit)
                        valid_in = 1'b1;
                  end
                  ACTION_PULSE: cmd.pulse_en = 1'b1;
                  ACTION_SEND: begin
                     cmd.send_en = 1'b1;
                     state_in    = S_SKIP;
                  end
                  default: ;
               endcase
            end
         end
         S_SKIP: begin
            if (status.tx_empty)
               state_in = S_IDLE;
            else if (status.tx_msb)
               state_in = S_EMIT;
            else
               cmd.skip_en = 1'b1;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit_en = 1'b1;
               valid_in    = 1'b1;
               if (status.tx_final)
                  state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.tick_en, cmd.pulse_en, cmd.send_en, cmd.skip_en, cmd.emit_en}))
      else $error("more than one datapath command");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_en || (cmd.tick_en && status.timeout_hit)) |-> out_free)
      else $error("result register loaded while still full");

   a_send_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.send_en |=> (state_ff == S_SKIP))
      else $error("send did not start the sequencer");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while sending");

endmodule

// ===== hdl/pulse_width_serial_transceiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_serial_transceiver
// Single-wire pulse-width coded transceiver: encodes frames into symbols and
// decodes measured pulse widths into a received frame with idle timeout.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    tuser action, tdata width + frame
//  rsp_     out  rsp_tvalid/tready    tuser kind, tlast, tdata symbol/frame
//  csr_     in   csr_valid/ready      csr_index, csr_data
//
//  A send loads the transmit shift register, shifts out its leading zeros
//  and then emits one symbol per remaining bit: the transmit shift register
//  moves one bit per cycle while rsp_tready does not hold an emit.
//  Reset loads the default settings and clears the receive state.
//  A stalled rsp_tready holds an emit; req_tready stays low while a
//  send is in progress or the result register cannot be refilled.
// ----------------------------------------------------------------------------
module pulse_width_serial_transceiver #(
   parameter int FRAME_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [55:0]                      req_tdata,  // pulse_width, frame_to_send
   input  logic [1:0]                       req_tuser,  // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // bit_value, high_time, low_time, received_frame, 7 pad bits
   output logic [71:0]                      rsp_tdata,
   output logic                             rsp_tuser,  // kind
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pwst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwst_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pwst_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic                bit_value;
   logic [TIME_W-1:0]   high_time, low_time;
   logic [WORD_W-1:0]   received_frame;

   assign csr_ready = 1'b1;

   pwst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pwst_dp #(
      .FRAME_BITS (FRAME_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .pulse_width    (req_tdata[23:0]),
      .frame_to_send  (req_tdata[55:24]),
      .cmd            (cmd),
      .status         (status),
      .kind           (rsp_tuser),
      .bit_value      (bit_value),
      .high_time      (high_time),
      .low_time       (low_time),
      .last           (rsp_tlast),
      .received_frame (received_frame)
   );

   assign rsp_tdata = {7'd0, received_frame, low_time, high_time, bit_value};

endmodule
